@@ hw/rtl/ecc_psm_pkg.sv @@
// Shared types, constants and codes for the prime-field scalar multiply unit.
`timescale 1ns / 1ps

package ecc_psm_pkg;

    localparam int FIELD_BITS = 30;
    localparam int WIDE_BITS  = FIELD_BITS + 1;
    localparam int CNT_W      = $clog2(FIELD_BITS);
    localparam int CFG_IDX_W  = 2;

    typedef logic [FIELD_BITS-1:0] fe_t;
    typedef logic [WIDE_BITS-1:0]  fe_wide_t;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ORDER = 2'd2;

    localparam fe_t MODULUS_RESET     = FIELD_BITS'(97);
    localparam fe_t COEFF_A_RESET     = FIELD_BITS'(2);
    localparam fe_t GROUP_ORDER_RESET = FIELD_BITS'(5);
    localparam fe_t MODULUS_MIN       = FIELD_BITS'(3);

    typedef struct packed {
        fe_t  scalar;
        fe_t  point_x;
        fe_t  point_y;
        logic point_is_infinity;
    } in_item_t;

    typedef struct packed {
        fe_t  result_x;
        fe_t  result_y;
        logic result_is_infinity;
        logic no_inverse;
    } out_item_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MOV,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_COPY,
        OP_ACC_INF,
        OP_ADDEND_INF,
        OP_FAIL,
        OP_FIN_ACC,
        OP_FIN_ADDEND,
        OP_KSHR,
        OP_OUT
    } op_t;

    // Datapath operand and destination registers
    typedef enum logic [4:0] {
        R_ZERO,
        R_ONE,
        R_P,
        R_N,
        R_CA,
        R_X1,
        R_Y1,
        R_X2,
        R_Y2,
        R_FA,
        R_LAM,
        R_U,
        R_V,
        R_R,
        R_NR,
        R_T,
        R_NT,
        R_Q,
        R_K
    } reg_sel_t;

    typedef struct packed {
        op_t      op;
        reg_sel_t dst;
        reg_sel_t src1;
        reg_sel_t src2;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic k_zero;
        logic k_bit0;
        logic k_last;
        logic inf1;
        logic inf2;
        logic x_eq;
        logic y_eq;
        logic y_opp;
        logic y2_zero;
        logic nr_zero;
        logic r_gt1;
        logic out_free;
    } stat_t;

    typedef enum logic [1:0] {
        MODE_ADD,
        MODE_DBLA,
        MODE_DBL2
    } mode_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_RED_K,
        S_RED_X,
        S_RED_Y,
        S_RED_A,
        S_CHECK,
        S_LOOP,
        S_ADD_BEGIN,
        S_DBL_BEGIN,
        S_AN0,
        S_AN1,
        S_DN0,
        S_DN1,
        S_DN2,
        S_DN3,
        S_DN4,
        S_INV0,
        S_INV1,
        S_INV2,
        S_IT0,
        S_IT1,
        S_IT2,
        S_IT3,
        S_IT4,
        S_IT5,
        S_IT6,
        S_IT7,
        S_LAM0,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_F4,
        S_F5,
        S_F6,
        S_STEP,
        S_FINISH
    } state_t;

endpackage

@@ hw/rtl/ecc_psm_ctrl.sv @@
// Sequencer for double-and-add, point formulas and the Euclid inverse.
`timescale 1ns / 1ps

module ecc_psm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ecc_psm_pkg::stat_t  stat,
    output ecc_psm_pkg::cmd_t   cmd
);
    import ecc_psm_pkg::*;

    state_t   state_reg, state_next;
    mode_t    mode_reg, mode_next;
    reg_sel_t base_x, base_y, other_x;

    // Hold state and point-operation mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_ADD;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        case (state_reg)
            S_IDLE:    if (s_valid) state_next = S_RED_K;
            S_RED_K:   if (stat.done) state_next = S_RED_X;
            S_RED_X:   if (stat.done) state_next = S_RED_Y;
            S_RED_Y:   if (stat.done) state_next = S_RED_A;
            S_RED_A:   if (stat.done) state_next = S_CHECK;
            S_CHECK:   state_next = (stat.k_zero || stat.inf2) ? S_FINISH : S_LOOP;
            S_LOOP:    state_next = stat.k_bit0 ? S_ADD_BEGIN : S_DBL_BEGIN;
            S_ADD_BEGIN: begin
                if (stat.inf1 || stat.inf2) begin
                    state_next = S_DBL_BEGIN;
                end else if (stat.x_eq && stat.y_opp) begin
                    state_next = S_DBL_BEGIN;
                end else if (stat.x_eq && stat.y_eq) begin
                    mode_next  = MODE_DBLA;
                    state_next = S_DN0;
                end else begin
                    mode_next  = MODE_ADD;
                    state_next = S_AN0;
                end
            end
            S_DBL_BEGIN: begin
                if (stat.inf2 || stat.y2_zero) begin
                    state_next = S_STEP;
                end else begin
                    mode_next  = MODE_DBL2;
                    state_next = S_DN0;
                end
            end
            S_AN0:     state_next = S_AN1;
            S_AN1:     state_next = S_INV0;
            S_DN0:     if (stat.done) state_next = S_DN1;
            S_DN1:     state_next = S_DN2;
            S_DN2:     state_next = S_DN3;
            S_DN3:     state_next = S_DN4;
            S_DN4:     state_next = S_INV0;
            S_INV0:    state_next = S_INV1;
            S_INV1:    state_next = S_INV2;
            S_INV2:    state_next = S_IT0;
            S_IT0: begin
                if (!stat.nr_zero)     state_next = S_IT1;
                else if (stat.r_gt1)   state_next = S_FINISH;
                else                   state_next = S_LAM0;
            end
            S_IT1:     if (stat.done) state_next = S_IT2;
            S_IT2:     state_next = S_IT3;
            S_IT3:     state_next = S_IT4;
            S_IT4:     if (stat.done) state_next = S_IT5;
            S_IT5:     state_next = S_IT6;
            S_IT6:     state_next = S_IT7;
            S_IT7:     state_next = S_IT0;
            S_LAM0:    if (stat.done) state_next = S_F0;
            S_F0:      if (stat.done) state_next = S_F1;
            S_F1:      state_next = S_F2;
            S_F2:      state_next = S_F3;
            S_F3:      state_next = S_F4;
            S_F4:      if (stat.done) state_next = S_F5;
            S_F5:      state_next = S_F6;
            S_F6:      state_next = (mode_reg == MODE_DBL2) ? S_STEP : S_DBL_BEGIN;
            S_STEP:    state_next = stat.k_last ? S_FINISH : S_LOOP;
            S_FINISH:  if (stat.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Operand roles for the current point operation
    always_comb begin
        base_x  = (mode_reg == MODE_DBL2) ? R_X2 : R_X1;
        base_y  = (mode_reg == MODE_DBL2) ? R_Y2 : R_Y1;
        other_x = (mode_reg == MODE_DBLA) ? R_X1 : R_X2;
    end

    // Commands to the datapath
    always_comb begin
        cmd      = '{op: OP_NOP, dst: R_ZERO, src1: R_ZERO, src2: R_ZERO};
        s_ready  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // Refuse beats while reset is held
                s_ready = aresetn;
                if (s_valid && aresetn) cmd.op = OP_LOAD;
            end
            S_RED_K: cmd = '{op: OP_DIV, dst: R_K,  src1: R_K,  src2: R_N};
            S_RED_X: cmd = '{op: OP_DIV, dst: R_X2, src1: R_X2, src2: R_P};
            S_RED_Y: cmd = '{op: OP_DIV, dst: R_Y2, src1: R_Y2, src2: R_P};
            S_RED_A: cmd = '{op: OP_DIV, dst: R_FA, src1: R_CA, src2: R_P};
            S_ADD_BEGIN: begin
                if (stat.inf1)                     cmd.op = OP_COPY;
                else if (stat.inf2)                cmd.op = OP_NOP;
                else if (stat.x_eq && stat.y_opp)  cmd.op = OP_ACC_INF;
            end
            S_DBL_BEGIN: if (stat.inf2 || stat.y2_zero) cmd.op = OP_ADDEND_INF;
            // Chord slope parts
            S_AN0: cmd = '{op: OP_SUB, dst: R_LAM, src1: R_Y2, src2: R_Y1};
            S_AN1: cmd = '{op: OP_SUB, dst: R_NR,  src1: R_X2, src2: R_X1};
            // Tangent slope parts: 3x^2 + a over 2y
            S_DN0: cmd = '{op: OP_MUL, dst: R_U,   src1: base_x, src2: base_x};
            S_DN1: cmd = '{op: OP_ADD, dst: R_V,   src1: R_U,    src2: R_U};
            S_DN2: cmd = '{op: OP_ADD, dst: R_V,   src1: R_V,    src2: R_U};
            S_DN3: cmd = '{op: OP_ADD, dst: R_LAM, src1: R_V,    src2: R_FA};
            S_DN4: cmd = '{op: OP_ADD, dst: R_NR,  src1: base_y, src2: base_y};
            // Euclid setup
            S_INV0: cmd = '{op: OP_MOV, dst: R_R,  src1: R_P,    src2: R_ZERO};
            S_INV1: cmd = '{op: OP_MOV, dst: R_T,  src1: R_ZERO, src2: R_ZERO};
            S_INV2: cmd = '{op: OP_MOV, dst: R_NT, src1: R_ONE,  src2: R_ZERO};
            S_IT0:  if (stat.nr_zero && stat.r_gt1) cmd.op = OP_FAIL;
            // One Euclid step, Bezout coefficient kept modulo p
            S_IT1: cmd = '{op: OP_DIV, dst: R_U,  src1: R_R,  src2: R_NR};
            S_IT2: cmd = '{op: OP_MOV, dst: R_R,  src1: R_NR, src2: R_ZERO};
            S_IT3: cmd = '{op: OP_MOV, dst: R_NR, src1: R_U,  src2: R_ZERO};
            S_IT4: cmd = '{op: OP_MUL, dst: R_U,  src1: R_NT, src2: R_Q};
            S_IT5: cmd = '{op: OP_SUB, dst: R_U,  src1: R_T,  src2: R_U};
            S_IT6: cmd = '{op: OP_MOV, dst: R_T,  src1: R_NT, src2: R_ZERO};
            S_IT7: cmd = '{op: OP_MOV, dst: R_NT, src1: R_U,  src2: R_ZERO};
            // Slope and new coordinates
            S_LAM0: cmd = '{op: OP_MUL, dst: R_LAM, src1: R_LAM,  src2: R_T};
            S_F0:   cmd = '{op: OP_MUL, dst: R_U,   src1: R_LAM,  src2: R_LAM};
            S_F1:   cmd = '{op: OP_SUB, dst: R_U,   src1: R_U,    src2: base_x};
            S_F2:   cmd = '{op: OP_SUB, dst: R_U,   src1: R_U,    src2: other_x};
            S_F3:   cmd = '{op: OP_SUB, dst: R_V,   src1: base_x, src2: R_U};
            S_F4:   cmd = '{op: OP_MUL, dst: R_V,   src1: R_LAM,  src2: R_V};
            S_F5:   cmd = '{op: OP_SUB, dst: R_V,   src1: R_V,    src2: base_y};
            S_F6:   cmd.op = (mode_reg == MODE_DBL2) ? OP_FIN_ADDEND : OP_FIN_ACC;
            S_STEP:   cmd.op = OP_KSHR;
            S_FINISH: if (stat.out_free) cmd.op = OP_OUT;
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/ecc_psm_dpath.sv @@
// Register file, serial modular multiplier and divider, config and result registers.
`timescale 1ns / 1ps

module ecc_psm_dpath (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  ecc_psm_pkg::cmd_t                        cmd,
    output ecc_psm_pkg::stat_t                       stat,
    input  logic                                     cfg_valid,
    input  logic [ecc_psm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ecc_psm_pkg::FIELD_BITS-1:0]       cfg_data,
    input  ecc_psm_pkg::in_item_t                    s_data,
    input  logic                                     m_ready,
    output logic                                     m_valid,
    output ecc_psm_pkg::out_item_t                   m_data
);
    import ecc_psm_pkg::*;

    fe_t modulus_reg, coeff_a_reg, group_order_reg;
    fe_t x1_reg, y1_reg, x2_reg, y2_reg, fa_reg, lam_reg, u_reg, v_reg;
    fe_t r_reg, nr_reg, t_reg, nt_reg, q_reg, k_reg;
    logic inf1_reg, inf2_reg, fail_reg;

    logic           busy_reg, is_div_reg;
    logic [CNT_W-1:0] cnt_reg;
    reg_sel_t       dst_reg;
    fe_t            opa_reg, opb_reg, quo_reg;
    fe_wide_t       acc_reg;
    logic           m_valid_reg;
    out_item_t      m_data_reg;

    fe_t      fp, fn, src1_val, src2_val, alu_val, wr_val, quo_next;
    fe_wide_t sum_w, diff_w, dbl_w, dbl_r, madd_w, madd_r, trial_w, rem_next, ysum_w;
    logic     multi_op, last_step, div_ge, wr_en;
    reg_sel_t wr_sel;

    // Effective modulus and order
    always_comb begin
        fp = (modulus_reg < MODULUS_MIN) ? MODULUS_MIN : modulus_reg;
        fn = (group_order_reg == '0) ? FIELD_BITS'(1) : group_order_reg;
    end

    function automatic fe_t read_sel(input reg_sel_t s);
        fe_t v;
        case (s)
            R_ZERO:  v = '0;
            R_ONE:   v = FIELD_BITS'(1);
            R_P:     v = fp;
            R_N:     v = fn;
            R_CA:    v = coeff_a_reg;
            R_X1:    v = x1_reg;
            R_Y1:    v = y1_reg;
            R_X2:    v = x2_reg;
            R_Y2:    v = y2_reg;
            R_FA:    v = fa_reg;
            R_LAM:   v = lam_reg;
            R_U:     v = u_reg;
            R_V:     v = v_reg;
            R_R:     v = r_reg;
            R_NR:    v = nr_reg;
            R_T:     v = t_reg;
            R_NT:    v = nt_reg;
            R_Q:     v = q_reg;
            R_K:     v = k_reg;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Modular add, subtract and move, computed combinationally
    always_comb begin
        src1_val = read_sel(cmd.src1);
        src2_val = read_sel(cmd.src2);
        sum_w    = {1'b0, src1_val} + {1'b0, src2_val};
        diff_w   = {1'b0, src1_val} + {1'b0, fp} - {1'b0, src2_val};
        case (cmd.op)
            OP_ADD:  alu_val = (sum_w >= {1'b0, fp}) ? FIELD_BITS'(sum_w - {1'b0, fp})
                                                     : sum_w[FIELD_BITS-1:0];
            OP_SUB:  alu_val = (src1_val >= src2_val) ? (src1_val - src2_val)
                                                      : diff_w[FIELD_BITS-1:0];
            default: alu_val = src1_val;
        endcase
    end

    // One step of the serial multiplier (double-and-add mod p) and the restoring divider
    always_comb begin
        dbl_w    = {acc_reg[FIELD_BITS-1:0], 1'b0};
        dbl_r    = (dbl_w >= {1'b0, fp}) ? (dbl_w - {1'b0, fp}) : dbl_w;
        madd_w   = dbl_r + (opb_reg[FIELD_BITS-1] ? {1'b0, opa_reg} : '0);
        madd_r   = (madd_w >= {1'b0, fp}) ? (madd_w - {1'b0, fp}) : madd_w;
        trial_w  = {acc_reg[FIELD_BITS-1:0], opb_reg[FIELD_BITS-1]};
        div_ge   = (trial_w >= {1'b0, opa_reg});
        rem_next = div_ge ? (trial_w - {1'b0, opa_reg}) : trial_w;
        quo_next = {quo_reg[FIELD_BITS-2:0], div_ge};
    end

    // Register write select
    always_comb begin
        multi_op  = (cmd.op == OP_MUL) || (cmd.op == OP_DIV);
        last_step = busy_reg && (cnt_reg == CNT_W'(FIELD_BITS - 1));
        wr_en     = 1'b0;
        wr_sel    = cmd.dst;
        wr_val    = alu_val;
        if (last_step) begin
            wr_en  = 1'b1;
            wr_sel = dst_reg;
            wr_val = is_div_reg ? rem_next[FIELD_BITS-1:0] : madd_r[FIELD_BITS-1:0];
        end else if (!busy_reg && ((cmd.op == OP_MOV) || (cmd.op == OP_ADD)
                                   || (cmd.op == OP_SUB))) begin
            wr_en = 1'b1;
        end
    end

    // Status to the sequencer
    always_comb begin
        ysum_w        = {1'b0, y1_reg} + {1'b0, y2_reg};
        stat.done     = multi_op ? last_step : 1'b1;
        stat.k_zero   = (k_reg == '0);
        stat.k_bit0   = k_reg[0];
        stat.k_last   = (k_reg[FIELD_BITS-1:1] == '0);
        stat.inf1     = inf1_reg;
        stat.inf2     = inf2_reg;
        stat.x_eq     = (x1_reg == x2_reg);
        stat.y_eq     = (y1_reg == y2_reg);
        stat.y_opp    = (ysum_w == '0) || (ysum_w == {1'b0, fp});
        stat.y2_zero  = (y2_reg == '0);
        stat.nr_zero  = (nr_reg == '0);
        stat.r_gt1    = (r_reg > FIELD_BITS'(1));
        stat.out_free = !m_valid_reg || m_ready;
    end

    // Control flags, config registers and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg     <= MODULUS_RESET;
            coeff_a_reg     <= COEFF_A_RESET;
            group_order_reg <= GROUP_ORDER_RESET;
            busy_reg        <= 1'b0;
            cnt_reg         <= '0;
            inf1_reg        <= 1'b1;
            inf2_reg        <= 1'b0;
            fail_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MODULUS:     modulus_reg     <= cfg_data;
                    CFG_COEFF_A:     coeff_a_reg     <= cfg_data;
                    CFG_GROUP_ORDER: group_order_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step) busy_reg <= 1'b0;
            end else if (multi_op) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            case (cmd.op)
                OP_LOAD: begin
                    inf1_reg <= 1'b1;
                    inf2_reg <= s_data.point_is_infinity;
                    fail_reg <= 1'b0;
                end
                OP_COPY:       inf1_reg <= inf2_reg;
                OP_ACC_INF:    inf1_reg <= 1'b1;
                OP_ADDEND_INF: inf2_reg <= 1'b1;
                OP_FAIL:       fail_reg <= 1'b1;
                OP_FIN_ACC:    inf1_reg <= 1'b0;
                default: ;
            endcase
            if (cmd.op == OP_OUT)  m_valid_reg <= 1'b1;
            else if (m_ready)      m_valid_reg <= 1'b0;
        end
    end

    // Operand registers and serial unit state
    always_ff @(posedge aclk) begin
        if (!busy_reg && multi_op) begin
            is_div_reg <= (cmd.op == OP_DIV);
            dst_reg    <= cmd.dst;
            opa_reg    <= (cmd.op == OP_DIV) ? src2_val : src1_val;
            opb_reg    <= (cmd.op == OP_DIV) ? src1_val : src2_val;
            acc_reg    <= '0;
            quo_reg    <= '0;
        end else if (busy_reg) begin
            opb_reg <= {opb_reg[FIELD_BITS-2:0], 1'b0};
            acc_reg <= is_div_reg ? rem_next : madd_r;
            quo_reg <= quo_next;
            if (last_step && is_div_reg) q_reg <= quo_next;
        end
        if (wr_en) begin
            case (wr_sel)
                R_X1:    x1_reg  <= wr_val;
                R_Y1:    y1_reg  <= wr_val;
                R_X2:    x2_reg  <= wr_val;
                R_Y2:    y2_reg  <= wr_val;
                R_FA:    fa_reg  <= wr_val;
                R_LAM:   lam_reg <= wr_val;
                R_U:     u_reg   <= wr_val;
                R_V:     v_reg   <= wr_val;
                R_R:     r_reg   <= wr_val;
                R_NR:    nr_reg  <= wr_val;
                R_T:     t_reg   <= wr_val;
                R_NT:    nt_reg  <= wr_val;
                R_K:     k_reg   <= wr_val;
                default: ;
            endcase
        end
        case (cmd.op)
            OP_LOAD: begin
                k_reg  <= s_data.scalar;
                x2_reg <= s_data.point_x;
                y2_reg <= s_data.point_y;
            end
            OP_COPY: begin
                x1_reg <= x2_reg;
                y1_reg <= y2_reg;
            end
            OP_FIN_ACC: begin
                x1_reg <= u_reg;
                y1_reg <= v_reg;
            end
            OP_FIN_ADDEND: begin
                x2_reg <= u_reg;
                y2_reg <= v_reg;
            end
            OP_KSHR: k_reg <= {1'b0, k_reg[FIELD_BITS-1:1]};
            OP_OUT: begin
                if (fail_reg) begin
                    m_data_reg <= '{result_x: '0, result_y: '0,
                                    result_is_infinity: 1'b0, no_inverse: 1'b1};
                end else if (inf1_reg) begin
                    m_data_reg <= '{result_x: '0, result_y: '0,
                                    result_is_infinity: 1'b1, no_inverse: 1'b0};
                end else begin
                    m_data_reg <= '{result_x: x1_reg, result_y: y1_reg,
                                    result_is_infinity: 1'b0, no_inverse: 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hw/rtl/ecc_prime_field_scalar_multiply_unit.sv @@
// Top level: scalar multiplication k*P on a short Weierstrass curve over GF(p).
//
//   channel  direction  handshake            beat
//   s_       in         s_valid / s_ready    in_item_t (scalar, point, identity flag)
//   m_       out        m_valid / m_ready    out_item_t (result, identity, no_inverse)
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (modulus, a, order)
//
// One item at a time. Reductions of k, x, y and a run in turn through the divider, each a
// load plus 30 divider steps. Each scalar bit costs up to one point add and one doubling,
// each plus the Euclid inverse, which runs one divide-and-update pass per quotient step.
// All field products go through one bit-serial multiplier.
// Reset is synchronous; config registers return to 97, 2 and 5.
// A waiting result stalls only the last state; the next beat is taken once it moves.
`timescale 1ns / 1ps

module ecc_prime_field_scalar_multiply_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  ecc_psm_pkg::in_item_t                s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ecc_psm_pkg::out_item_t               m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ecc_psm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ecc_psm_pkg::FIELD_BITS-1:0]   cfg_data
);
    import ecc_psm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Take config writes once out of reset
    assign cfg_ready = aresetn;

    ecc_psm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ecc_psm_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    // Identity and failure never both flagged
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.result_is_infinity && m_data.no_inverse))
        else $error("identity and no_inverse both set");

    // Identity or failure result carries zero coordinates
    a_zero_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.result_is_infinity || m_data.no_inverse))
            |-> (m_data.result_x == '0) && (m_data.result_y == '0))
        else $error("coordinates not cleared");

    // An accepted beat makes the block busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

endmodule
